// File: src/pdc_pkg.sv
// shared types, codes and constants for the pulse duration classifier
`default_nettype none

package pdc_pkg;

   localparam int TABLE_DEPTH_DEF = 16;

   localparam int DURATION_W  = 16;
   localparam int ENTRY_W     = 15;
   localparam int TOL_W       = 15;
   localparam int MIN_W       = 5;
   localparam int INDEX_OUT_W = 4;
   localparam int COUNT_OUT_W = 5;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 15;

   localparam logic [TOL_W-1:0] TOLERANCE_RESET   = TOL_W'(50);
   localparam logic [MIN_W-1:0] MIN_ENTRIES_RESET = MIN_W'(4);

   typedef enum logic [1:0] {
      ACTION_CLEAR  = 2'd0,
      ACTION_APPEND = 2'd1,
      ACTION_QUERY  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_MATCH   = 2'd1,
      STATUS_NOMATCH = 2'd2,
      STATUS_FULL    = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MATCH_TOLERANCE     = 1'd0,
      CSR_NEAREST_MIN_ENTRIES = 1'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      PDC_IDLE,
      PDC_SCAN,
      PDC_REPLY
   } state_type;

   typedef struct packed {
      logic [1:0]                   action;
      logic signed [DURATION_W-1:0] pulse_duration;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [INDEX_OUT_W-1:0] match_index;
      logic [COUNT_OUT_W-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic [TOL_W-1:0] match_tolerance;
      logic [MIN_W-1:0] nearest_min_entries;
   } cfg_type;

endpackage : pdc_pkg

`default_nettype wire

// File: src/pdc_table.sv
// reference duration memory, one write and one registered read port
`default_nettype none

module pdc_table #(
   parameter int TABLE_DEPTH = pdc_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0]   wr_addr,
   input  wire logic [pdc_pkg::ENTRY_W-1:0]      wr_data,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
   output logic      [pdc_pkg::ENTRY_W-1:0]      rd_data
);
   import pdc_pkg::*;

   logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : pdc_table

`default_nettype wire

// File: src/pdc_engine.sv
// sequencer and shared difference/compare unit that scans the table
`default_nettype none

module pdc_engine #(
   parameter int TABLE_DEPTH = pdc_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_fire,
   input  wire pdc_pkg::req_type                 req,
   input  wire pdc_pkg::cfg_type                 cfg,
   input  wire logic                             slot_free,
   output logic                                  busy,
   output logic                                  done,
   output pdc_pkg::rsp_type                      result,
   output logic                                  wr_en,
   output logic      [$clog2(TABLE_DEPTH)-1:0]   wr_addr,
   output logic      [pdc_pkg::ENTRY_W-1:0]      wr_data,
   output logic      [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
   input  wire logic [pdc_pkg::ENTRY_W-1:0]      rd_data
);
   import pdc_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > MIN_W) ? CNT_W : MIN_W;
   localparam int CO_W  = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [DURATION_W-1:0]    mag_ff, mag_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [DURATION_W-1:0]    best_ff, best_in;
   logic [IDX_W-1:0]         best_idx_ff, best_idx_in;
   status_type               status_ff, status_in;
   logic [IDX_W-1:0]         index_ff, index_in;

   logic [DURATION_W-1:0]    req_mag;
   logic [DURATION_W-1:0]    entry_ext;
   logic [DURATION_W-1:0]    diff;
   logic                     last_entry;
   logic                     min_ok;

   // magnitude of the signed duration, 0..32768
   assign req_mag = req.pulse_duration[DURATION_W-1]
                    ? (~req.pulse_duration + DURATION_W'(1))
                    : req.pulse_duration;

   // shared difference unit
   assign entry_ext  = {1'b0, rd_data};
   assign diff       = (entry_ext >= mag_ff) ? (entry_ext - mag_ff) : (mag_ff - entry_ext);
   assign last_entry = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
   assign min_ok     = CMP_W'(count_ff) >= CMP_W'(cfg.nearest_min_entries);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PDC_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      mag_ff      <= mag_in;
      idx_ff      <= idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      status_ff   <= status_in;
      index_ff    <= index_in;
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      mag_in      = mag_ff;
      idx_in      = idx_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      status_in   = status_ff;
      index_in    = index_ff;
      wr_en       = 1'b0;
      wr_addr     = count_ff[IDX_W-1:0];
      wr_data     = req_mag[DURATION_W-1] ? {ENTRY_W{1'b1}} : req_mag[ENTRY_W-1:0];
      rd_addr     = '0;
      busy        = (state_ff != PDC_IDLE);
      done        = 1'b0;

      case (state_ff)
         PDC_IDLE: begin
            if (req_fire) begin
               status_in = STATUS_DONE;
               index_in  = '0;
               state_in  = PDC_REPLY;
               case (req.action)
                  ACTION_CLEAR: begin
                     count_in = '0;
                  end
                  ACTION_APPEND: begin
                     if (count_ff >= DEPTH_CNT) begin
                        status_in = STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  ACTION_QUERY: begin
                     mag_in = req_mag;
                     idx_in = '0;
                     if (count_ff == '0) begin
                        status_in = STATUS_NOMATCH;
                     end else begin
                        state_in = PDC_SCAN;
                     end
                  end
                  default: begin
                     status_in = STATUS_DONE;
                  end
               endcase
            end
         end
         PDC_SCAN: begin
            // fetch the next entry while comparing the current one
            rd_addr = idx_ff + IDX_W'(1);
            if (diff <= DURATION_W'(cfg.match_tolerance)) begin
               status_in = STATUS_MATCH;
               index_in  = idx_ff;
               state_in  = PDC_REPLY;
            end else begin
               if ((idx_ff == '0) || (diff < best_ff)) begin
                  best_in     = diff;
                  best_idx_in = idx_ff;
               end
               if (last_entry) begin
                  state_in = PDC_REPLY;
                  if (min_ok) begin
                     status_in = STATUS_MATCH;
                     index_in  = ((idx_ff == '0) || (diff < best_ff)) ? idx_ff : best_idx_ff;
                  end else begin
                     status_in = STATUS_NOMATCH;
                  end
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         PDC_REPLY: begin
            done = 1'b1;
            if (slot_free) begin
               state_in = PDC_IDLE;
            end
         end
         default: begin
            state_in = PDC_IDLE;
         end
      endcase
   end

   assign result.status      = status_ff;
   assign result.match_index = INDEX_OUT_W'(index_ff);
   assign result.entry_count = COUNT_OUT_W'(CO_W'(count_ff));

endmodule : pdc_engine

`default_nettype wire

// File: src/pulse_duration_classifier_top.sv
// top level of the pulse duration classifier: handshakes, csrs, output register
// clear and append pass through the reply state into the output register;
//   a query scans the entries in order and stops early at the first one within tolerance
// one request at a time, taken only when the sequencer is back in idle; the scan
//   reads one entry per cycle through one compare unit; a stalled response holds off requests
// reset: synchronous, active high; empties the table, restores tolerance 50 and minimum 4
`default_nettype none

module pulse_duration_classifier_top #(
   parameter int TABLE_DEPTH = pdc_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire pdc_pkg::req_type                    req_data,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output pdc_pkg::rsp_type                         rsp_data,
   // csr write port
   input  wire logic                                csr_we,
   input  wire logic [pdc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [pdc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import pdc_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   cfg_type              cfg_ff, cfg_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 req_fire;
   logic                 busy;
   logic                 done;
   logic                 slot_free;
   rsp_type              result;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [ENTRY_W-1:0]   wr_data;
   logic [IDX_W-1:0]     rd_addr;
   logic [ENTRY_W-1:0]   rd_data;

   // a request is taken only while the sequencer is idle
   assign req_stall = busy;
   assign req_fire  = req_valid && !req_stall;

   // output register frees up when empty or when its response is taken
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // csr writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MATCH_TOLERANCE: begin
               cfg_in.match_tolerance = csr_wdata[TOL_W-1:0];
            end
            CSR_NEAREST_MIN_ENTRIES: begin
               cfg_in.nearest_min_entries = csr_wdata[MIN_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (done && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.match_tolerance     <= TOLERANCE_RESET;
         cfg_ff.nearest_min_entries <= MIN_ENTRIES_RESET;
         rsp_valid_ff               <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // scan sequencer with the shared compare unit
   pdc_engine #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req       (req_data),
      .cfg       (cfg_ff),
      .slot_free (slot_free),
      .busy      (busy),
      .done      (done),
      .result    (result),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   // reference duration storage
   pdc_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule : pulse_duration_classifier_top

`default_nettype wire

// File: tb/sv/pulse_duration_classifier_top_tb.sv
// self-checking testbench for the pulse duration classifier top level
`timescale 1ns / 1ps

module pulse_duration_classifier_top_tb;
   import pdc_pkg::*;

   localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
   // no-op action code, not part of the package enum
   localparam logic [1:0] ACTION_UNUSED = 2'd3;
   // cycles with no request or response taken before the run is declared hung
   localparam int QUIET_LIMIT = 4000;
   localparam int RANDOM_PER_PHASE = 280;
   localparam int PHASES = 6;
   localparam int OWED_DEPTH = 16;
   localparam int ROWS_MAX = 32;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // mirror of the block: table contents, fill level and csr settings
   logic [ENTRY_W-1:0] reference_durations [TABLE_DEPTH];
   int durations_held;
   int unsigned tolerance_now;
   int unsigned min_entries_now;

   // responses owed by the block, oldest first, kept in a ring
   rsp_type pending_replies [OWED_DEPTH];
   int owed_wr = 0;
   int owed_rd = 0;
   int fail_count = 0;
   int quiet_cycles = 0;
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;

   // csr settings per random phase: both extremes of each register, plus a
   // minimum above the table depth that never allows the nearest fallback
   int unsigned tolerance_plan [PHASES] = '{0, 32767, 50, 200, 5, 1000};
   int unsigned min_entries_plan [PHASES] = '{0, 16, 31, 1, 16, 4};

   typedef struct {
      req_type request;
      int      copies;
      bit      typed;
      rsp_type reply;
   } directed_row_type;

   directed_row_type directed_rows [ROWS_MAX];
   int row_count = 0;

   pulse_duration_classifier_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // expected response for one request; updates the mirrored table
   function automatic rsp_type classify_request(input req_type r);
      rsp_type     reply;
      int unsigned mag;
      int unsigned gap;
      int unsigned best_gap;
      int          best_at;
      bit          hit;
      reply = '0;
      // magnitude 0..32768, the most negative value is not saturated here
      mag = r.pulse_duration[15] ? 32'h10000 - 32'(r.pulse_duration[15:0])
                                 : 32'(r.pulse_duration[15:0]);
      case (r.action)
         ACTION_CLEAR: begin
            durations_held = 0;
         end
         ACTION_APPEND: begin
            if (durations_held >= TABLE_DEPTH) begin
               reply.status = STATUS_FULL;
            end else begin
               // stored entries are only 15 bits wide
               reference_durations[durations_held] = (mag > 32767) ? 15'h7fff : 15'(mag);
               durations_held++;
            end
         end
         ACTION_QUERY: begin
            hit = 1'b0;
            best_at = -1;
            best_gap = 0;
            for (int i = 0; i < durations_held; i++) begin
               gap = (reference_durations[i] > mag) ? reference_durations[i] - mag
                                                    : mag - reference_durations[i];
               // first entry within tolerance ends the scan
               if (gap <= tolerance_now) begin
                  hit = 1'b1;
                  best_at = i;
                  break;
               end
               // strict compare keeps the lowest index on ties
               if (best_at < 0 || gap < best_gap) begin
                  best_at = i;
                  best_gap = gap;
               end
            end
            if (hit || (best_at >= 0 && durations_held >= min_entries_now)) begin
               reply.status = STATUS_MATCH;
               reply.match_index = INDEX_OUT_W'(best_at);
            end else begin
               reply.status = STATUS_NOMATCH;
            end
         end
         default: begin
            // unused action: nothing changes
         end
      endcase
      reply.entry_count = COUNT_OUT_W'(durations_held);
      return reply;
   endfunction

   // duration biased toward table entries and the tolerance boundary
   function automatic logic signed [15:0] pick_duration();
      int          v;
      int          spread;
      int unsigned choice;
      choice = $urandom_range(99);
      if (choice < 10) begin
         case ($urandom_range(5))
            0: return 16'sh8000;
            1: return -16'sd32767;
            2: return 16'sd32767;
            3: return 16'sd0;
            4: return 16'sd1;
            default: return -16'sd1;
         endcase
      end else if (choice < 55 && durations_held > 0) begin
         v = reference_durations[$urandom_range(durations_held - 1)];
         case ($urandom_range(3))
            0: spread = 0;
            1: spread = tolerance_now;
            2: spread = tolerance_now + 1;
            default: spread = $urandom_range(2 * tolerance_now + 64);
         endcase
         v = $urandom_range(1) ? v + spread : v - spread;
         if (v < 0) v = -v;
         if (v > 32768) v = 32768;
      end else if (choice < 80) begin
         v = $urandom_range(3000);
      end else begin
         return 16'($urandom);
      end
      // random sign; a query must ignore it
      return 16'($urandom_range(1) ? -v : v);
   endfunction

   function automatic req_type random_request();
      req_type     r;
      int unsigned pick;
      pick = $urandom_range(99);
      // clears are rare so the table regularly fills up
      if (pick < 2) r.action = ACTION_CLEAR;
      else if (pick < 4) r.action = ACTION_UNUSED;
      else if (pick < 42) r.action = ACTION_APPEND;
      else r.action = ACTION_QUERY;
      r.pulse_duration = pick_duration();
      return r;
   endfunction

   function automatic directed_row_type row(input logic [1:0] action, input int duration,
                                            input int copies, input bit typed,
                                            input status_type status, input int index,
                                            input int count);
      directed_row_type d;
      d.request.action = action;
      d.request.pulse_duration = 16'(duration);
      d.copies = copies;
      d.typed = typed;
      d.reply.status = status;
      d.reply.match_index = INDEX_OUT_W'(index);
      d.reply.entry_count = COUNT_OUT_W'(count);
      return d;
   endfunction

   // append one row to the directed table
   task automatic add_row(input directed_row_type d);
      directed_rows[row_count] = d;
      row_count++;
   endtask

   // log one owed response at the tail of the ring
   task automatic owe_reply(input rsp_type expected);
      pending_replies[owed_wr % OWED_DEPTH] = expected;
      owed_wr++;
   endtask

   // present one request, hold it until taken, then log its expected response
   task automatic issue_request(input req_type r, input bit typed, input rsp_type typed_reply);
      rsp_type predicted;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      predicted = classify_request(r);
      owe_reply(typed ? typed_reply : predicted);
   endtask

   // drop valid and wait for every owed response
   task automatic wait_for_replies();
      req_valid <= 1'b0;
      while (owed_wr != owed_rd) @(posedge clock);
      @(posedge clock);
   endtask

   // both csr writes back to back, only while the block is idle
   task automatic write_settings(input int unsigned tolerance, input int unsigned min_entries);
      csr_we <= 1'b1;
      csr_index <= CSR_MATCH_TOLERANCE;
      csr_wdata <= CSR_DATA_W'(tolerance);
      @(posedge clock);
      csr_index <= CSR_NEAREST_MIN_ENTRIES;
      csr_wdata <= CSR_DATA_W'(min_entries);
      @(posedge clock);
      csr_we <= 1'b0;
      tolerance_now = tolerance & 32'h7fff;
      min_entries_now = min_entries & 32'h1f;
   endtask

   // response side: random stall and in-order compare
   always @(posedge clock) begin : check_replies
      rsp_type wanted;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_wr == owed_rd) begin
               $error("response with none pending: status %0d index %0d count %0d",
                      rsp_data.status, rsp_data.match_index, rsp_data.entry_count);
               fail_count++;
            end else begin
               wanted = pending_replies[owed_rd % OWED_DEPTH];
               owed_rd++;
               if (rsp_data.status !== wanted.status) begin
                  $error("status expected %0d got %0d", wanted.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.match_index !== wanted.match_index) begin
                  $error("match_index expected %0d got %0d",
                         wanted.match_index, rsp_data.match_index);
                  fail_count++;
               end
               if (rsp_data.entry_count !== wanted.entry_count) begin
                  $error("entry_count expected %0d got %0d",
                         wanted.entry_count, rsp_data.entry_count);
                  fail_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // hang detection: no handshake on either channel for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL pulse_duration_classifier_top");
         $finish;
      end
   end

   initial begin
      // every input known from time zero
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_MATCH_TOLERANCE;
      csr_wdata <= '0;
      send_idle_pct = 24;
      recv_stall_pct = 63;
      durations_held = 0;
      tolerance_now = TOLERANCE_RESET;
      min_entries_now = MIN_ENTRIES_RESET;

      // directed part under reset settings: tolerance 50, minimum 4
      // empty table never matches
      add_row(row(ACTION_QUERY, 100, 1, 1, STATUS_NOMATCH, 0, 0));
      add_row(row(ACTION_APPEND, 1000, 1, 1, STATUS_DONE, 0, 1));
      // most negative value saturates to 32767 when stored
      add_row(row(ACTION_APPEND, -32768, 1, 1, STATUS_DONE, 0, 2));
      add_row(row(ACTION_APPEND, 32767, 1, 1, STATUS_DONE, 0, 3));
      // magnitude 32768 compared unsaturated, one away from entry 1
      add_row(row(ACTION_QUERY, -32768, 1, 1, STATUS_MATCH, 1, 3));
      // nothing within tolerance and below the minimum: no fallback
      add_row(row(ACTION_QUERY, 20000, 1, 1, STATUS_NOMATCH, 0, 3));
      add_row(row(ACTION_APPEND, 0, 1, 1, STATUS_DONE, 0, 4));
      // nearest fallback with a tie between entries 1 and 2
      add_row(row(ACTION_QUERY, 20000, 1, 0, STATUS_DONE, 0, 0));
      // negative query exactly at the tolerance boundary
      add_row(row(ACTION_QUERY, -1050, 1, 0, STATUS_DONE, 0, 0));
      add_row(row(ACTION_UNUSED, 1234, 1, 1, STATUS_DONE, 0, 4));
      // fill the table to the top
      add_row(row(ACTION_APPEND, -1, 12, 0, STATUS_DONE, 0, 0));
      // append to a full table is dropped
      add_row(row(ACTION_APPEND, 7, 1, 1, STATUS_FULL, 0, 16));
      add_row(row(ACTION_QUERY, 1, 1, 0, STATUS_DONE, 0, 0));
      add_row(row(ACTION_CLEAR, 0, 1, 1, STATUS_DONE, 0, 0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < row_count; i++) begin
         repeat (directed_rows[i].copies) begin
            issue_request(directed_rows[i].request, directed_rows[i].typed,
                          directed_rows[i].reply);
         end
      end

      // random phases, each with its own csr settings
      for (int phase = 0; phase < PHASES; phase++) begin
         // idling: sender light/receiver heavy, then swapped, then none
         if (phase == 2) begin
            send_idle_pct = 63;
            recv_stall_pct = 24;
         end else if (phase == 4) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         wait_for_replies();
         write_settings(tolerance_plan[phase], min_entries_plan[phase]);
         repeat (RANDOM_PER_PHASE) issue_request(random_request(), 1'b0, '0);
      end

      wait_for_replies();
      // allow for a late stray response after the last one
      repeat (24) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS pulse_duration_classifier_top");
      end else begin
         $display("FAIL pulse_duration_classifier_top");
      end
      $finish;
   end

endmodule
